### rtl/tplc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tplc_pkg
// Shared types and constants of the two-point linear calibration block.
// ----------------------------------------------------------------------------
package tplc_pkg;

   localparam int REG_WIDTH   = 16;
   localparam int DEN_WIDTH   = 16;
   localparam int OUT_WIDTH   = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int DIV_STEPS   = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_A_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_A_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_B_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_B_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_EN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_FLOOR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CEILING = 3'd6;

   localparam logic [REG_WIDTH-1:0] RST_POINT_A_X   = 16'h0000;
   localparam logic [REG_WIDTH-1:0] RST_POINT_A_Y   = 16'h0000;
   localparam logic [REG_WIDTH-1:0] RST_POINT_B_X   = 16'h0001;
   localparam logic [REG_WIDTH-1:0] RST_POINT_B_Y   = 16'h0001;
   localparam logic [REG_WIDTH-1:0] RST_OUT_FLOOR   = 16'h8000;
   localparam logic [REG_WIDTH-1:0] RST_OUT_CEILING = 16'h7FFF;

   typedef struct packed {
      logic signed [REG_WIDTH-1:0] point_a_x;
      logic signed [REG_WIDTH-1:0] point_a_y;
      logic signed [REG_WIDTH-1:0] point_b_x;
      logic signed [REG_WIDTH-1:0] point_b_y;
      logic                        clamp_enable;
      logic signed [REG_WIDTH-1:0] out_floor;
      logic signed [REG_WIDTH-1:0] out_ceiling;
   } tplc_cfg_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic err;
   } tplc_ctl_type;

endpackage
`default_nettype wire

### rtl/tplc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tplc_front
// Differences, magnitudes and sign, product, and rounding offset: three stages.
// ----------------------------------------------------------------------------
module tplc_front #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int DX_WIDTH     = 17,
   parameter int PROD_WIDTH   = 33,
   parameter int NUM_WIDTH    = 34
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
   input  wire tplc_pkg::tplc_cfg_type         cfg,
   output tplc_pkg::tplc_ctl_type              out_ctl,
   output logic [tplc_pkg::DEN_WIDTH-1:0]      out_den,
   output logic [NUM_WIDTH-1:0]                out_num
);
   import tplc_pkg::*;

   logic signed [DX_WIDTH-1:0]  dx;
   logic signed [REG_WIDTH:0]   dy;
   logic signed [REG_WIDTH:0]   dxb;

   tplc_ctl_type                ctl1_in, ctl1_ff, ctl2_ff, ctl3_ff;
   logic [DX_WIDTH-1:0]         adx_in, adx_ff;
   logic [DEN_WIDTH-1:0]        ady_in, ady_ff;
   logic [DEN_WIDTH-1:0]        den1_in, den1_ff, den2_ff, den3_ff;
   logic [PROD_WIDTH-1:0]       prod_in, prod_ff;
   logic [NUM_WIDTH-1:0]        num_in, num_ff;

   always_comb begin
      dx  = DX_WIDTH'(in_sample) - DX_WIDTH'(cfg.point_a_x);
      dy  = (REG_WIDTH+1)'(cfg.point_b_y) - (REG_WIDTH+1)'(cfg.point_a_y);
      dxb = (REG_WIDTH+1)'(cfg.point_b_x) - (REG_WIDTH+1)'(cfg.point_a_x);
      adx_in  = dx[DX_WIDTH-1] ? DX_WIDTH'(-dx) : DX_WIDTH'(dx);
      ady_in  = dy[REG_WIDTH] ? DEN_WIDTH'(-dy) : dy[DEN_WIDTH-1:0];
      den1_in = dxb[REG_WIDTH] ? DEN_WIDTH'(-dxb) : dxb[DEN_WIDTH-1:0];
      ctl1_in.valid = in_valid;
      ctl1_in.neg   = dx[DX_WIDTH-1] ^ dy[REG_WIDTH] ^ dxb[REG_WIDTH];
      ctl1_in.err   = (cfg.point_a_x == cfg.point_b_x) ||
                      (cfg.clamp_enable && (cfg.out_floor > cfg.out_ceiling));
   end

   assign prod_in = PROD_WIDTH'(adx_ff) * PROD_WIDTH'(ady_ff);
   assign num_in  = NUM_WIDTH'(prod_ff) + NUM_WIDTH'(den2_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      adx_ff  <= adx_in;
      ady_ff  <= ady_in;
      den1_ff <= den1_in;
      prod_ff <= prod_in;
      den2_ff <= den1_ff;
      num_ff  <= num_in;
      den3_ff <= den2_ff;
   end

   assign out_ctl = ctl3_ff;
   assign out_den = den3_ff;
   assign out_num = num_ff;

endmodule
`default_nettype wire

### rtl/tplc_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tplc_div_stage
// One registered stage of the restoring divider: STEPS quotient bits a cycle.
// ----------------------------------------------------------------------------
module tplc_div_stage #(
   parameter int PAD_WIDTH = 36,
   parameter int STEPS     = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tplc_pkg::tplc_ctl_type        in_ctl,
   input  wire logic [tplc_pkg::DEN_WIDTH-1:0] in_den,
   input  wire logic [tplc_pkg::DEN_WIDTH-1:0] in_rem,
   input  wire logic [PAD_WIDTH-1:0]          in_work,
   output tplc_pkg::tplc_ctl_type             out_ctl,
   output logic [tplc_pkg::DEN_WIDTH-1:0]     out_den,
   output logic [tplc_pkg::DEN_WIDTH-1:0]     out_rem,
   output logic [PAD_WIDTH-1:0]               out_work
);
   import tplc_pkg::*;

   tplc_ctl_type           ctl_ff;
   logic [DEN_WIDTH-1:0]   den_ff;
   logic [DEN_WIDTH-1:0]   rem_in, rem_ff;
   logic [PAD_WIDTH-1:0]   work_in, work_ff;

   always_comb begin
      logic [DEN_WIDTH:0] trial;
      logic               ge;
      rem_in  = in_rem;
      work_in = in_work;
      for (int i = 0; i < STEPS; i++) begin
         trial   = {rem_in, work_in[PAD_WIDTH-1]};
         ge      = (trial >= {1'b0, in_den});
         rem_in  = ge ? DEN_WIDTH'(trial - {1'b0, in_den}) : trial[DEN_WIDTH-1:0];
         work_in = {work_in[PAD_WIDTH-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= in_den;
      rem_ff  <= rem_in;
      work_ff <= work_in;
   end

   assign out_ctl  = ctl_ff;
   assign out_den  = den_ff;
   assign out_rem  = rem_ff;
   assign out_work = work_ff;

endmodule
`default_nettype wire

### rtl/tplc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tplc_back
// Apply sign, add the first point's output, then clamp or saturate; an invalid setting gives zero.
// ----------------------------------------------------------------------------
module tplc_back #(
   parameter int PAD_WIDTH = 36
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tplc_pkg::tplc_ctl_type             in_ctl,
   input  wire logic [PAD_WIDTH-1:0]               in_quot,
   input  wire tplc_pkg::tplc_cfg_type             cfg,
   output logic                                    out_strobe,
   output logic signed [tplc_pkg::OUT_WIDTH-1:0]   out_value,
   output logic                                    out_status
);
   import tplc_pkg::*;

   localparam int Y_WIDTH = PAD_WIDTH + 2;
   localparam logic signed [Y_WIDTH-1:0] SAT_HI =
      {{(Y_WIDTH-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [Y_WIDTH-1:0] SAT_LO =
      {{(Y_WIDTH-OUT_WIDTH+1){1'b1}}, {(OUT_WIDTH-1){1'b0}}};

   logic signed [Y_WIDTH-1:0]   term;
   logic signed [Y_WIDTH-1:0]   y_in, y_ff;
   tplc_ctl_type                ctl_ff;
   logic signed [Y_WIDTH-1:0]   lo, hi, sel;
   logic                        strobe_ff;
   logic signed [OUT_WIDTH-1:0] value_in, value_ff;
   logic                        status_ff;

   always_comb begin
      term = in_ctl.neg ? -signed'(Y_WIDTH'(in_quot)) : signed'(Y_WIDTH'(in_quot));
      y_in = Y_WIDTH'(cfg.point_a_y) + term;
   end

   always_comb begin
      lo  = cfg.clamp_enable ? Y_WIDTH'(cfg.out_floor) : SAT_LO;
      hi  = cfg.clamp_enable ? Y_WIDTH'(cfg.out_ceiling) : SAT_HI;
      sel = y_ff;
      if (sel < lo) begin
         sel = lo;
      end
      if (sel > hi) begin
         sel = hi;
      end
      value_in = ctl_ff.err ? '0 : sel[OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctl_ff    <= in_ctl;
         strobe_ff <= ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      y_ff      <= y_in;
      value_ff  <= value_in;
      status_ff <= ctl_ff.err;
   end

   assign out_strobe = strobe_ff;
   assign out_value  = value_ff;
   assign out_status = status_ff;

endmodule
`default_nettype wire

### rtl/two_point_linear_calibration_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_point_linear_calibration_top
// Maps raw samples through the line set by two calibration points.
// ----------------------------------------------------------------------------
// A sample is taken whenever start is high; busy is always low, so one sample
// may enter in every cycle. Each sample gives exactly one result, shown for one
// cycle with rsp_strobe high, after it passes three front stages (differences,
// product, rounding offset), the divider pipeline retiring four quotient bits
// per stage, and two back stages (add, clamp). Results must be taken as they
// appear. Write the calibration registers only while no sample is in flight;
// rsp_status flags equal x points or an inverted clamp range with clamping on.
// ----------------------------------------------------------------------------
module two_point_linear_calibration_top #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [SAMPLE_WIDTH-1:0]      req_raw_sample,
   output logic                                     rsp_strobe,
   output logic signed [tplc_pkg::OUT_WIDTH-1:0]    rsp_mapped_value,
   output logic                                     rsp_status,
   input  wire logic                                csr_we,
   input  wire logic [tplc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tplc_pkg::REG_WIDTH-1:0]      csr_wdata
);
   import tplc_pkg::*;

   localparam int DX_WIDTH   = ((SAMPLE_WIDTH > REG_WIDTH) ? SAMPLE_WIDTH : REG_WIDTH) + 1;
   localparam int PROD_WIDTH = DX_WIDTH + DEN_WIDTH;
   localparam int NUM_WIDTH  = PROD_WIDTH + 1;
   localparam int NUM_STAGES = (NUM_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
   localparam int PAD_WIDTH  = NUM_STAGES * DIV_STEPS;

   tplc_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point_a_x    <= RST_POINT_A_X;
         cfg_ff.point_a_y    <= RST_POINT_A_Y;
         cfg_ff.point_b_x    <= RST_POINT_B_X;
         cfg_ff.point_b_y    <= RST_POINT_B_Y;
         cfg_ff.clamp_enable <= 1'b0;
         cfg_ff.out_floor    <= RST_OUT_FLOOR;
         cfg_ff.out_ceiling  <= RST_OUT_CEILING;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POINT_A_X:   cfg_ff.point_a_x    <= csr_wdata;
            CSR_POINT_A_Y:   cfg_ff.point_a_y    <= csr_wdata;
            CSR_POINT_B_X:   cfg_ff.point_b_x    <= csr_wdata;
            CSR_POINT_B_Y:   cfg_ff.point_b_y    <= csr_wdata;
            CSR_CLAMP_EN:    cfg_ff.clamp_enable <= csr_wdata[0];
            CSR_OUT_FLOOR:   cfg_ff.out_floor    <= csr_wdata;
            CSR_OUT_CEILING: cfg_ff.out_ceiling  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign busy = 1'b0;

   tplc_ctl_type           ctl_chain  [0:NUM_STAGES];
   logic [DEN_WIDTH-1:0]   den_chain  [0:NUM_STAGES];
   logic [DEN_WIDTH-1:0]   rem_chain  [0:NUM_STAGES];
   logic [PAD_WIDTH-1:0]   work_chain [0:NUM_STAGES];
   logic [NUM_WIDTH-1:0]   front_num;

   tplc_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .DX_WIDTH     (DX_WIDTH),
      .PROD_WIDTH   (PROD_WIDTH),
      .NUM_WIDTH    (NUM_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_sample (req_raw_sample),
      .cfg       (cfg_ff),
      .out_ctl   (ctl_chain[0]),
      .out_den   (den_chain[0]),
      .out_num   (front_num)
   );

   assign rem_chain[0]  = '0;
   assign work_chain[0] = PAD_WIDTH'(front_num);

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_div
      tplc_div_stage #(
         .PAD_WIDTH (PAD_WIDTH),
         .STEPS     (DIV_STEPS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_ctl   (ctl_chain[s]),
         .in_den   (den_chain[s]),
         .in_rem   (rem_chain[s]),
         .in_work  (work_chain[s]),
         .out_ctl  (ctl_chain[s+1]),
         .out_den  (den_chain[s+1]),
         .out_rem  (rem_chain[s+1]),
         .out_work (work_chain[s+1])
      );
   end

   tplc_back #(
      .PAD_WIDTH (PAD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (ctl_chain[NUM_STAGES]),
      .in_quot    (work_chain[NUM_STAGES]),
      .cfg        (cfg_ff),
      .out_strobe (rsp_strobe),
      .out_value  (rsp_mapped_value),
      .out_status (rsp_status)
   );

endmodule
`default_nettype wire

### bench/tb_two_point_linear_calibration_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_two_point_linear_calibration_top
// Self-checking bench for the two-point linear calibration block.
// ----------------------------------------------------------------------------
// The bench loads a series of calibration settings through the register port,
// always with the pipeline empty. After each load it sends a burst of raw
// samples with random gaps. Every accepted sample is mapped by a local
// calculation of the line, with rounding, clamping and saturation, and the
// strobed results are checked in order against it. A directed opening covers
// the sample extremes, rounding of halves, saturation at both ends, equal x
// points, an inverted clamp range and writes to the unused register index.
// About fourteen hundred random samples then run under random settings.
// ----------------------------------------------------------------------------
module tb_two_point_linear_calibration_top;
   import tplc_pkg::*;

   localparam int SAMPLE_WIDTH = 16;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_SETS  = 14;
   localparam int SET_ITEMS    = 100;
   localparam int DRAIN_CYCLES = 25;
   localparam int ROUND_DIV    = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic signed [OUT_WIDTH-1:0] value;
      logic                        status;
   } calib_result_type;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      int unsigned                    gap;
   } sample_item_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic signed [SAMPLE_WIDTH-1:0] req_raw_sample = '0;
   logic                           rsp_strobe;
   logic signed [OUT_WIDTH-1:0]    rsp_mapped_value;
   logic                           rsp_status;
   logic                           csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]           csr_index = '0;
   logic [REG_WIDTH-1:0]           csr_wdata = '0;

   sample_item_type  pending_samples[$];
   calib_result_type expected_results[$];
   tplc_cfg_type     cal_regs;

   sample_item_type  staged;
   bit            have_staged = 1'b0;
   int unsigned   gap_left = 0;
   bit            taken = 1'b0;

   int unsigned   items_queued = 0;
   int unsigned   items_accepted = 0;
   int unsigned   results_checked = 0;
   int unsigned   flagged_count = 0;
   int unsigned   settings_count = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;

   two_point_linear_calibration_top #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_raw_sample(req_raw_sample),
      .rsp_strobe(rsp_strobe),
      .rsp_mapped_value(rsp_mapped_value),
      .rsp_status(rsp_status),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic calib_result_type calibrate_sample(logic signed [SAMPLE_WIDTH-1:0] sample);
      longint x, ax, ay, bx, by, lo, hi, num, den, term, y;
      calib_result_type r;
      x  = sample;
      ax = $signed(cal_regs.point_a_x);
      ay = $signed(cal_regs.point_a_y);
      bx = $signed(cal_regs.point_b_x);
      by = $signed(cal_regs.point_b_y);
      lo = $signed(cal_regs.out_floor);
      hi = $signed(cal_regs.out_ceiling);
      if (ax == bx || (cal_regs.clamp_enable && lo > hi)) begin
         r.value  = '0;
         r.status = 1'b1;
         return r;
      end
      num = (x - ax) * (by - ay);
      den = bx - ax;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num >= 0)
         term = (num + den / ROUND_DIV) / den;
      else
         term = (num - den / ROUND_DIV) / den;
      y = ay + term;
      if (cal_regs.clamp_enable) begin
         if (y < lo) y = lo;
         if (y > hi) y = hi;
      end else begin
         if (y < -64'sd2147483648) y = -64'sd2147483648;
         if (y > 64'sd2147483647) y = 64'sd2147483647;
      end
      r.value  = y[OUT_WIDTH-1:0];
      r.status = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want,
                  got);
   endtask

   // sender: hold an item until taken, then idle for the gap of the next one
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         have_staged = 1'b0;
         gap_left = 0;
      end else if (!(start && !taken)) begin
         if (!have_staged && pending_samples.size() != 0) begin
            staged = pending_samples.pop_front();
            gap_left = staged.gap;
            have_staged = 1'b1;
         end
         if (have_staged && gap_left == 0) begin
            start <= 1'b1;
            req_raw_sample <= staged.sample;
            have_staged = 1'b0;
         end else begin
            start <= 1'b0;
            if (have_staged)
               gap_left--;
         end
      end
   end

   always @(posedge clock) begin
      calib_result_type want;
      if (reset) begin
         cal_regs.point_a_x    = RST_POINT_A_X;
         cal_regs.point_a_y    = RST_POINT_A_Y;
         cal_regs.point_b_x    = RST_POINT_B_X;
         cal_regs.point_b_y    = RST_POINT_B_Y;
         cal_regs.clamp_enable = 1'b0;
         cal_regs.out_floor    = RST_OUT_FLOOR;
         cal_regs.out_ceiling  = RST_OUT_CEILING;
         taken = 1'b0;
      end else begin
         if (rsp_strobe) begin
            results_checked++;
            if (rsp_status)
               flagged_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, value", 0, rsp_mapped_value);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mapped_value !== want.value)
                  report_mismatch("mapped_value", want.value, rsp_mapped_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
            end
         end
         taken = start && !busy;
         if (taken) begin
            expected_results.push_back(calibrate_sample(req_raw_sample));
            items_accepted++;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_POINT_A_X:   cal_regs.point_a_x = csr_wdata;
               CSR_POINT_A_Y:   cal_regs.point_a_y = csr_wdata;
               CSR_POINT_B_X:   cal_regs.point_b_x = csr_wdata;
               CSR_POINT_B_Y:   cal_regs.point_b_y = csr_wdata;
               CSR_CLAMP_EN:    cal_regs.clamp_enable = csr_wdata[0];
               CSR_OUT_FLOOR:   cal_regs.out_floor = csr_wdata;
               CSR_OUT_CEILING: cal_regs.out_ceiling = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic apply_settings(tplc_cfg_type s);
      logic [REG_WIDTH-1:0] clamp_word;
      clamp_word = REG_WIDTH'($urandom);
      clamp_word[0] = s.clamp_enable;
      write_reg(CSR_POINT_A_X, s.point_a_x);
      write_reg(CSR_POINT_A_Y, s.point_a_y);
      write_reg(CSR_POINT_B_X, s.point_b_x);
      write_reg(CSR_POINT_B_Y, s.point_b_y);
      write_reg(CSR_CLAMP_EN, clamp_word);
      write_reg(CSR_OUT_FLOOR, s.out_floor);
      write_reg(CSR_OUT_CEILING, s.out_ceiling);
      if ($urandom_range(3) == 0)
         write_reg(CSR_SPARE, REG_WIDTH'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   task automatic queue_sample(logic signed [SAMPLE_WIDTH-1:0] sample, int unsigned gap);
      sample_item_type it;
      it.sample = sample;
      it.gap    = gap;
      pending_samples.push_back(it);
      items_queued++;
   endtask

   // hold until every queued item is taken and every result has come back
   task automatic wait_for_drain();
      while (items_accepted != items_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic tplc_cfg_type line_settings(int ax, int ay, int bx, int by);
      tplc_cfg_type s;
      s.point_a_x    = REG_WIDTH'(ax);
      s.point_a_y    = REG_WIDTH'(ay);
      s.point_b_x    = REG_WIDTH'(bx);
      s.point_b_y    = REG_WIDTH'(by);
      s.clamp_enable = 1'b0;
      s.out_floor    = RST_OUT_FLOOR;
      s.out_ceiling  = RST_OUT_CEILING;
      return s;
   endfunction

   function automatic tplc_cfg_type random_settings();
      tplc_cfg_type s;
      int pick;
      logic signed [REG_WIDTH-1:0] swap;
      s.point_a_x = REG_WIDTH'($urandom);
      s.point_a_y = REG_WIDTH'($urandom);
      s.point_b_y = REG_WIDTH'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) begin
         s.point_b_x = REG_WIDTH'($urandom);
      end else if (pick < 82) begin
         s.point_b_x = REG_WIDTH'(s.point_a_x +
                                  ($urandom_range(1) ? 1 : -1) * $urandom_range(1, 4));
         if ($urandom_range(1))
            s.point_b_y = REG_WIDTH'(s.point_a_y + $urandom_range(0, 14) - 7);
      end else if (pick < 90) begin
         s.point_b_x = s.point_a_x;
      end else begin
         s.point_a_x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         s.point_b_x = REG_WIDTH'(s.point_a_x + ($urandom_range(1) ? 1 : -1));
         s.point_a_y = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         s.point_b_y = ~s.point_a_y;
      end
      s.clamp_enable = 1'($urandom_range(1));
      s.out_floor    = REG_WIDTH'($urandom);
      s.out_ceiling  = REG_WIDTH'($urandom);
      pick = $urandom_range(99);
      if (pick < 5)
         s.out_ceiling = s.out_floor;
      else if (pick < 80 && s.out_floor > s.out_ceiling) begin
         swap          = s.out_floor;
         s.out_floor   = s.out_ceiling;
         s.out_ceiling = swap;
      end
      return s;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] random_sample(tplc_cfg_type s);
      logic [SAMPLE_WIDTH-1:0] raw;
      int pick;
      pick = $urandom_range(99);
      raw = SAMPLE_WIDTH'($urandom);
      if (pick >= 90) begin
         case ($urandom_range(3))
            0: raw = 16'h8000;
            1: raw = 16'h7FFF;
            2: raw = 16'h0000;
            default: raw = 16'hFFFF;
         endcase
      end else if (pick >= 70) begin
         raw = SAMPLE_WIDTH'(($urandom_range(1) ? s.point_a_x : s.point_b_x) +
                             $urandom_range(0, 8) - 4);
      end
      return raw;
   endfunction

   function automatic int unsigned pick_gap(bit idle_enabled);
      int pick;
      if (!idle_enabled)
         return 0;
      pick = $urandom_range(99);
      if (pick < 55)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   initial begin
      tplc_cfg_type s;
      bit idle_enabled;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state maps samples onto themselves
      queue_sample(16'sh8000, 0);
      queue_sample(16'sh7FFF, 0);
      queue_sample(16'sh0000, 1);
      queue_sample(-16'sd1, 0);
      queue_sample(16'sh5555, 0);
      wait_for_drain();

      // halves round away from zero
      apply_settings(line_settings(0, 0, 2, 1));
      queue_sample(16'sd1, 0);
      queue_sample(-16'sd1, 0);
      queue_sample(16'sd3, 2);
      queue_sample(-16'sd3, 0);
      wait_for_drain();

      // steepest slope, saturate high
      apply_settings(line_settings(-32768, -32768, -32767, 32767));
      queue_sample(16'sh7FFF, 0);
      queue_sample(16'sh8000, 0);
      wait_for_drain();

      // negative denominator, saturate low
      apply_settings(line_settings(-32767, -32768, -32768, 32767));
      queue_sample(16'sh7FFF, 0);
      queue_sample(16'sh8000, 0);
      wait_for_drain();

      // equal x points, plus a write to the unused index
      apply_settings(line_settings(100, 5, 100, 9));
      write_reg(CSR_SPARE, 16'h1234);
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      queue_sample(16'sd100, 0);
      wait_for_drain();

      // inverted clamp range with clamping on
      s = line_settings(0, 0, 1, 1);
      s.clamp_enable = 1'b1;
      s.out_floor    = 16'sd10;
      s.out_ceiling  = -16'sd10;
      apply_settings(s);
      queue_sample(16'sd50, 0);
      wait_for_drain();

      // same range ignored with clamping off, upper enable bits set
      write_reg(CSR_CLAMP_EN, 16'hFFFE);
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      queue_sample(16'sd50, 0);
      wait_for_drain();

      // narrow clamp range
      s = line_settings(0, 0, 1, 1);
      s.clamp_enable = 1'b1;
      s.out_floor    = -16'sd100;
      s.out_ceiling  = 16'sd100;
      apply_settings(s);
      queue_sample(16'sh8000, 0);
      queue_sample(16'sh7FFF, 0);
      queue_sample(16'sd5, 0);
      wait_for_drain();

      // full clamp range at the extremes
      s = line_settings(0, 0, 1, 2);
      s.clamp_enable = 1'b1;
      apply_settings(s);
      queue_sample(16'sh7FFF, 0);
      queue_sample(16'sh8000, 0);
      wait_for_drain();

      for (int set = 0; set < RANDOM_SETS; set++) begin
         s = random_settings();
         apply_settings(s);
         idle_enabled = ($urandom_range(3) != 0);
         for (int n = 0; n < SET_ITEMS; n++)
            queue_sample(random_sample(s), pick_gap(idle_enabled));
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered, count", 0, expected_results.size());

      $display("mapped %0d samples under %0d calibration settings; %0d results checked",
               items_accepted, settings_count, results_checked);
      $display("%0d results flagged an invalid setting; %0d mismatches", flagged_count,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
rtl/tplc_pkg.sv
rtl/tplc_front.sv
rtl/tplc_div_stage.sv
rtl/tplc_back.sv
rtl/two_point_linear_calibration_top.sv
bench/tb_two_point_linear_calibration_top.sv
